/* design/tcw_pkg.sv */
// shared types and constants for the text console writer
// no dependencies; imported by tcw_engine and text_console_writer_top
package tcw_pkg;

    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int NIB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CELL_W    = 2 * CHAR_W;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [CHAR_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;
    localparam logic [NIB_W-1:0]  FG_RESET     = 4'hF;
    localparam logic [NIB_W-1:0]  BG_RESET     = 4'h0;

    // result bookkeeping handed from the engine to the output stage
    typedef struct packed {
        logic valid;
        logic is_read;
        logic in_range;
    } t_res_ctl;

endpackage

/* design/text_console_writer_top.sv */
// top level of the text console writer: color registers, cell memory, result stage
// depends on tcw_pkg, tcw_ram and tcw_engine
//
// channel   direction  handshake                 payload
// item      in         start high, busy low      i_mode, i_character, i_read_row, i_read_col
// result    out        o_done, one-cycle strobe  o_cell_char, o_cell_color,
//                                                o_cursor_row, o_cursor_col
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// puts, reads and unused modes stay in idle; the result is registered in engine, then here
// clear writes every cell in turn; a newline on the last row, or a character with a wrap
// pending there, scrolls: rows move up, the last row is blanked, the character is placed;
// both write one cell at a time through the single write port of the cell memory
// after reset a clearing pass keeps busy high
// o_cfg_ready is always high; the result side has no back-pressure
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tcw_pkg::MODE_W-1:0]        i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]        i_character,
    input  logic [tcw_pkg::ROW_W-1:0]         i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]         i_read_col,
    output logic                              o_done,
    output logic [tcw_pkg::CHAR_W-1:0]        o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]        o_cell_color,
    output logic [tcw_pkg::ROW_W-1:0]         o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]         o_cursor_col,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::NIB_W-1:0]         i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    logic [NIB_W-1:0]  r_fg;
    logic [NIB_W-1:0]  r_bg;
    logic              r_done;
    logic [CHAR_W-1:0] r_cell_char;
    logic [CHAR_W-1:0] r_cell_color;
    logic [ROW_W-1:0]  r_cursor_row;
    logic [COL_W-1:0]  r_cursor_col;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    t_res_ctl          res;
    logic [RW-1:0]     cur_row;
    logic [CW-1:0]     cur_col;
    logic              show_cell;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_mode      (i_mode),
        .i_character (i_character),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_color     ({r_bg, r_fg}),
        .i_rdata     (mem_rdata),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .o_res       (res),
        .o_row       (cur_row),
        .o_col       (cur_col)
    );

    assign show_cell = res.is_read && res.in_range;

    always_ff @(posedge i_clk) begin
        r_cell_char  <= show_cell ? mem_rdata[CHAR_W-1:0] : '0;
        r_cell_color <= show_cell ? mem_rdata[CELL_W-1:CHAR_W] : '0;
        r_cursor_row <= ROW_W'(cur_row);
        r_cursor_col <= COL_W'(cur_col);
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res.valid;
        end
    end

    assign o_done       = r_done;
    assign o_cell_char  = r_cell_char;
    assign o_cell_color = r_cell_color;
    assign o_cursor_row = r_cursor_row;
    assign o_cursor_col = r_cursor_col;

    a_done_follows_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(res.valid))
        else $error("result strobe without a finished transaction");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(cur_col) <= 32'(COLUMNS))
        else $error("cursor column beyond wrap position");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(cur_row) < 32'(ROWS))
        else $error("cursor row out of range");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_CLEAR) |=> busy)
        else $error("clear accepted without holding busy");
endmodule

/* design/tcw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/tcw_engine.sv */
// cursor and sequencer: drives the cell memory ports for puts, reads, clear and scroll
// depends on tcw_pkg
module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [tcw_pkg::MODE_W-1:0]           i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]           i_character,
    input  logic [tcw_pkg::ROW_W-1:0]            i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]            i_read_col,
    input  logic [tcw_pkg::CHAR_W-1:0]           i_color,
    input  logic [tcw_pkg::CELL_W-1:0]           i_rdata,
    output logic                                 o_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      o_waddr,
    output logic [tcw_pkg::CELL_W-1:0]           o_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      o_raddr,
    output tcw_pkg::t_res_ctl                    o_res,
    output logic [$clog2(ROWS)-1:0]              o_row,
    output logic [$clog2(COLUMNS+1)-1:0]         o_col
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int MOVE  = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] MOVE_BASE = AW'(MOVE);
    localparam logic [AW-1:0] MOVE_END  = AW'(MOVE - 1);
    localparam logic [AW-1:0] CELL_END  = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_BLANK,
        ST_PUT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic            r_init, n_init;
    logic            r_put_pend, n_put_pend;
    logic [CHAR_W-1:0] r_put_char, n_put_char;
    logic            r_mv_valid, n_mv_valid;
    logic [AW-1:0]   r_mv_addr, n_mv_addr;
    t_res_ctl        r_res, n_res;

    logic            wrap;
    logic            last;
    logic [RW-1:0]   put_row;
    logic [CW-1:0]   put_col;
    logic [AW-1:0]   put_addr;
    logic [AW-1:0]   rd_addr_in;
    logic            rd_in_range;

    assign wrap     = (r_col >= COL_MAX);
    assign last     = (r_row == LAST_ROW);
    assign put_row  = wrap ? (r_row + RW'(1)) : r_row;
    assign put_col  = wrap ? '0 : r_col;
    assign put_addr = AW'(AW'(put_row) * COLS_A) + AW'(put_col);

    assign rd_addr_in  = AW'(AW'(i_read_row) * COLS_A) + AW'(i_read_col);
    assign rd_in_range = (32'(i_read_row) < 32'(ROWS)) && (32'(i_read_col) < 32'(COLUMNS));

    // scroll reads one row ahead of the write address
    assign o_raddr = (r_state == ST_SCROLL) ? (r_cnt + COLS_A) : rd_addr_in;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_init     = r_init;
        n_put_pend = r_put_pend;
        n_put_char = r_put_char;
        n_mv_valid = 1'b0;
        n_mv_addr  = r_cnt;
        n_res      = '0;
        o_we       = 1'b0;
        o_waddr    = put_addr;
        o_wdata    = {i_color, i_character};

        // moved cell from the previous scroll read owns the write port
        if (r_mv_valid) begin
            o_we    = 1'b1;
            o_waddr = r_mv_addr;
            o_wdata = i_rdata;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_res.valid = 1'b1;
                    unique case (i_mode)
                        MODE_PUT: begin
                            if (i_character == NEWLINE_BYTE) begin
                                n_col = '0;
                                if (last) begin
                                    n_res.valid = 1'b0;
                                    n_state     = ST_SCROLL;
                                    n_cnt       = '0;
                                    n_put_pend  = 1'b0;
                                end else begin
                                    n_row = r_row + RW'(1);
                                end
                            end else if (wrap && last) begin
                                n_res.valid = 1'b0;
                                n_col       = '0;
                                n_state     = ST_SCROLL;
                                n_cnt       = '0;
                                n_put_pend  = 1'b1;
                                n_put_char  = i_character;
                            end else begin
                                o_we  = 1'b1;
                                n_row = put_row;
                                n_col = put_col + CW'(1);
                            end
                        end
                        MODE_CLEAR: begin
                            n_res.valid = 1'b0;
                            n_state     = ST_CLEAR;
                            n_cnt       = '0;
                            n_init      = 1'b0;
                        end
                        MODE_READ: begin
                            n_res.is_read  = 1'b1;
                            n_res.in_range = rd_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt;
                o_wdata = {(r_init ? RESET_COLOR : i_color), SPACE_BYTE};
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == CELL_END) begin
                    n_state     = ST_IDLE;
                    n_init      = 1'b0;
                    n_res.valid = !r_init;
                end
            end
            ST_SCROLL: begin
                n_mv_valid = 1'b1;
                n_mv_addr  = r_cnt;
                n_cnt      = r_cnt + AW'(1);
                if (r_cnt == MOVE_END) begin
                    n_state = ST_BLANK;
                    n_cnt   = MOVE_BASE;
                end
            end
            ST_BLANK: begin
                if (!r_mv_valid) begin
                    o_we    = 1'b1;
                    o_waddr = r_cnt;
                    o_wdata = {i_color, SPACE_BYTE};
                    n_cnt   = r_cnt + AW'(1);
                    if (r_cnt == CELL_END) begin
                        if (r_put_pend) begin
                            n_state = ST_PUT;
                        end else begin
                            n_state     = ST_IDLE;
                            n_res.valid = 1'b1;
                        end
                    end
                end
            end
            ST_PUT: begin
                o_we        = 1'b1;
                o_waddr     = MOVE_BASE;
                o_wdata     = {i_color, r_put_char};
                n_col       = CW'(1);
                n_put_pend  = 1'b0;
                n_state     = ST_IDLE;
                n_res.valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_put_char <= n_put_char;
        r_mv_addr  <= n_mv_addr;
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_init     <= 1'b1;
            r_put_pend <= 1'b0;
            r_mv_valid <= 1'b0;
            r_res      <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_init     <= n_init;
            r_put_pend <= n_put_pend;
            r_mv_valid <= n_mv_valid;
            r_res      <= n_res;
        end
    end

    assign o_busy = (r_state != ST_IDLE) || !i_rst_n;
    assign o_res  = r_res;
    assign o_row  = r_row;
    assign o_col  = r_col;
endmodule
